[rtl/dsc_pkg.sv]
package dsc_pkg;

   localparam int STATE_BITS     = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREQ      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESONANCE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STAGE_AMT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET       = 3'd4;

   typedef enum logic [4:0] {
      ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7,
      ST_C8, ST_C9, ST_C10, ST_C11, ST_C12, ST_C13,
      ST_IDLE, ST_LD,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
      ST_G1, ST_G2, ST_X1, ST_X2, ST_X3, ST_OUT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      MUL_NONE, MUL_FF, MUL_F2F, MUL_F3F, MUL_R015, MUL_RCRC, MUL_A0RR, MUL_BF3,
      MUL_B_DIFF, MUL_CFB_T, MUL_A_X, MUL_CFA_LT, MUL_Y_W, MUL_O_W,
      MUL_X_GAIN, MUL_X_WET, MUL_DRY_WET
   } mul_sel_type;

   typedef enum logic [3:0] {
      WB_NONE, WB_F2, WB_F3, WB_A0, WB_RC, WB_RR, WB_B, WB_A,
      WB_NT, WB_Y, WB_X16, WB_OUT
   } wb_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        accum;
      wb_sel_type  wb_sel;
      logic        accept;
      logic        load_state;
      logic        idx_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic stage_on;
      logic last_stage;
      logic gain_on;
      logic wet_on;
   } dp_status_type;

endpackage

[rtl/double_exp_smoothing_cascade_top.sv]
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    req_sample_in
// rsp      out        rsp_valid/rsp_ready    rsp_sample_out
// csr      in         csr_we                 csr_index, csr_wdata
//
// One shared multiply-accumulate unit does all the work: an item is accepted,
// runs through every engaged stage in turn, then through bypass check, gain,
// mix and output.
// Reset and every register write start a coefficient pass; req_ready is
// low meanwhile. A result waiting in the output register stalls only the next
// item's final write; the next item is taken as soon as the current one is done.
module double_exp_smoothing_cascade_top
   import dsc_pkg::*;
#(
   parameter int NUM_STAGES  = 8,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 16
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   dsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_write (csr_we),
      .status    (status),
      .cmd       (cmd)
   );

   dsc_datapath #(
      .NUM_STAGES  (NUM_STAGES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample_in  (req_sample_in),
      .rsp_sample_out (rsp_sample_out),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

[rtl/dsc_ctrl.sv]
module dsc_ctrl
   import dsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic          csr_write,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_C0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_NONE;
      cmd.wb_sel  = WB_NONE;
      out_load    = 1'b0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_C0: begin cmd.mul_sel = MUL_FF; state_in = ST_C1; end
         ST_C1: begin cmd.wb_sel = WB_F2; state_in = ST_C2; end
         ST_C2: begin cmd.mul_sel = MUL_F2F; state_in = ST_C3; end
         ST_C3: begin cmd.wb_sel = WB_F3; state_in = ST_C4; end
         ST_C4: begin cmd.mul_sel = MUL_F3F; state_in = ST_C5; end
         ST_C5: begin cmd.wb_sel = WB_A0; state_in = ST_C6; end
         ST_C6: begin cmd.mul_sel = MUL_R015; state_in = ST_C7; end
         ST_C7: begin cmd.wb_sel = WB_RC; state_in = ST_C8; end
         ST_C8: begin cmd.mul_sel = MUL_RCRC; state_in = ST_C9; end
         ST_C9: begin cmd.wb_sel = WB_RR; state_in = ST_C10; end
         ST_C10: begin cmd.mul_sel = MUL_A0RR; state_in = ST_C11; end
         ST_C11: begin cmd.wb_sel = WB_B; state_in = ST_C12; end
         ST_C12: begin cmd.mul_sel = MUL_BF3; state_in = ST_C13; end
         ST_C13: begin cmd.wb_sel = WB_A; state_in = ST_IDLE; end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LD;
            end
         end
         ST_LD: begin
            cmd.load_state = 1'b1;
            state_in = status.stage_on ? ST_M1 : ST_G1;
         end
         ST_M1: begin cmd.mul_sel = MUL_B_DIFF; state_in = ST_M2; end
         ST_M2: begin cmd.mul_sel = MUL_CFB_T; cmd.accum = 1'b1; state_in = ST_M3; end
         ST_M3: begin
            cmd.mul_sel = MUL_A_X;
            cmd.wb_sel  = WB_NT;
            state_in    = ST_M4;
         end
         ST_M4: begin cmd.mul_sel = MUL_CFA_LT; cmd.accum = 1'b1; state_in = ST_M5; end
         ST_M5: begin cmd.wb_sel = WB_Y; state_in = ST_M6; end
         ST_M6: begin cmd.mul_sel = MUL_Y_W; state_in = ST_M7; end
         ST_M7: begin cmd.mul_sel = MUL_O_W; cmd.accum = 1'b1; state_in = ST_M8; end
         ST_M8: begin
            cmd.wb_sel  = WB_X16;
            cmd.idx_inc = 1'b1;
            state_in    = status.last_stage ? ST_G1 : ST_LD;
         end
         ST_G1: begin
            if (status.gain_on) begin
               cmd.mul_sel = MUL_X_GAIN;
               state_in    = ST_G2;
            end else begin
               state_in = ST_X1;
            end
         end
         ST_G2: begin cmd.wb_sel = WB_X16; state_in = ST_X1; end
         ST_X1: begin
            if (status.wet_on) begin
               cmd.mul_sel = MUL_X_WET;
               state_in    = ST_X2;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_X2: begin cmd.mul_sel = MUL_DRY_WET; cmd.accum = 1'b1; state_in = ST_X3; end
         ST_X3: begin cmd.wb_sel = WB_X16; state_in = ST_OUT; end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.wb_sel = WB_OUT;
               out_load   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_C0;
      endcase
      if (csr_write) begin
         state_in = ST_C0;
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/dsc_datapath.sv]
module dsc_datapath
   import dsc_pkg::*;
#(
   parameter int NUM_STAGES  = 8,
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 16
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status
);

   localparam int IDX_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam int CW    = COEF_BITS + 2;
   localparam int OPA_W = 34;
   localparam int OPB_W = (CW > 18) ? CW : 18;
   localparam int PRD_W = OPA_W + OPB_W;
   localparam int ACC_W = PRD_W + 1;
   localparam int SW    = STATE_BITS;

   localparam longint ONE_L  = 64'sd1 << COEF_BITS;
   localparam longint EPS_L  = (ONE_L + 50000) / 100000;
   localparam longint C015_L = (15 * ONE_L + 50) / 100;
   localparam longint C012_L = (12 * ONE_L + 50) / 100;
   localparam longint K999_L = (999 * ONE_L + 500) / 1000;

   localparam logic signed [ACC_W-1:0] ONE_A  = ACC_W'(ONE_L);
   localparam logic signed [ACC_W-1:0] EPS_A  = ACC_W'(EPS_L);
   localparam logic signed [ACC_W-1:0] C012_A = ACC_W'(C012_L);
   localparam logic signed [CW-1:0]    ONE_C  = CW'(ONE_L);
   localparam logic signed [CW-1:0]    C015_C = CW'(C015_L);
   localparam logic signed [CW-1:0]    K999_C = CW'(K999_L);
   localparam logic signed [ACC_W-1:0] HALF_C = ACC_W'(64'sd1 << (COEF_BITS - 1));
   localparam logic signed [ACC_W-1:0] HALF_16 = ACC_W'(32768);
   localparam logic signed [ACC_W-1:0] S32_MAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] S32_MIN = ~S32_MAX;
   localparam logic signed [SW-1:0] SMP_MAX =
      {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] SMP_MIN = ~SMP_MAX;

   logic [15:0] freq_ff, res_ff;
   logic [19:0] amt_ff;
   logic [16:0] gain_ff, wet_ff;

   logic signed [CW-1:0] f2_ff, f3_ff, a0_ff, rc_ff, rr_ff, b_ff, a_ff;
   logic signed [SW-1:0] lvl_ff [NUM_STAGES];
   logic signed [SW-1:0] trd_ff [NUM_STAGES];
   logic signed [SW-1:0] dry_ff, x_ff, lv_ff, tr_ff, nt_ff, y_ff, prev_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   logic [COEF_BITS+15:0] fk, rk;
   logic [COEF_BITS-1:0]  f, r;
   logic signed [CW-1:0]  cfa, cfb, one_minus_b;
   logic signed [SW:0]    d, lt;
   logic signed [SW-1:0]  other;
   logic signed [21:0]    wdiff;
   logic [16:0]           w, wc, wetc;
   logic signed [OPA_W-1:0] opa;
   logic signed [OPB_W-1:0] opb;
   logic signed [PRD_W-1:0] prod;
   logic signed [ACC_W-1:0] rnd_c, rnd_16, sat_c, a0_t, a_t;
   logic signed [SW-1:0]    out_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= 16'd32768;
         res_ff  <= 16'd32768;
         amt_ff  <= 20'd65536;
         gain_ff <= 17'd65536;
         wet_ff  <= 17'd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FREQ:      freq_ff <= csr_wdata[15:0];
            CSR_RESONANCE: res_ff  <= csr_wdata[15:0];
            CSR_STAGE_AMT: amt_ff  <= csr_wdata;
            CSR_GAIN:      gain_ff <= csr_wdata[16:0];
            CSR_WET:       wet_ff  <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   assign fk = {freq_ff, COEF_BITS'(0)};
   assign rk = {res_ff, COEF_BITS'(0)};
   assign f  = fk[COEF_BITS+15:16];
   assign r  = rk[COEF_BITS+15:16];

   assign cfa         = K999_C - a_ff;
   assign cfb         = K999_C - b_ff;
   assign one_minus_b = ONE_C - b_ff;
   assign d           = (SW+1)'(x_ff) - (SW+1)'(lv_ff);
   assign lt          = (SW+1)'(lv_ff) + (SW+1)'(tr_ff);
   assign other       = (idx_ff == '0) ? dry_ff : prev_ff;

   assign wdiff = $signed({2'b00, amt_ff}) - $signed(22'({idx_ff, 16'd0}));
   assign w     = (wdiff > 22'sd65536) ? 17'd65536 : wdiff[16:0];
   assign wc    = 17'd65536 - w;
   assign wetc  = 17'd65536 - wet_ff;

   assign status.stage_on   = (wdiff > 22'sd0);
   assign status.last_stage = (idx_ff == IDX_W'(NUM_STAGES - 1));
   assign status.gain_on    = (gain_ff < 17'd65536);
   assign status.wet_on     = (wet_ff < 17'd65536);

   always_comb begin
      opa = '0;
      opb = '0;
      case (cmd.mul_sel)
         MUL_FF:      begin opa = OPA_W'({1'b0, f}); opb = OPB_W'({1'b0, f}); end
         MUL_F2F:     begin opa = OPA_W'(f2_ff); opb = OPB_W'({1'b0, f}); end
         MUL_F3F:     begin opa = OPA_W'(f3_ff); opb = OPB_W'({1'b0, f}); end
         MUL_R015:    begin opa = OPA_W'({1'b0, r}); opb = OPB_W'(C015_C); end
         MUL_RCRC:    begin opa = OPA_W'(rc_ff); opb = OPB_W'(rc_ff); end
         MUL_A0RR:    begin opa = OPA_W'(a0_ff); opb = OPB_W'(rr_ff); end
         MUL_BF3:     begin opa = OPA_W'(one_minus_b); opb = OPB_W'(f3_ff); end
         MUL_B_DIFF:  begin opa = OPA_W'(d); opb = OPB_W'(b_ff); end
         MUL_CFB_T:   begin opa = OPA_W'(tr_ff); opb = OPB_W'(cfb); end
         MUL_A_X:     begin opa = OPA_W'(x_ff); opb = OPB_W'(a_ff); end
         MUL_CFA_LT:  begin opa = OPA_W'(lt); opb = OPB_W'(cfa); end
         MUL_Y_W:     begin opa = OPA_W'(y_ff); opb = OPB_W'({1'b0, w}); end
         MUL_O_W:     begin opa = OPA_W'(other); opb = OPB_W'({1'b0, wc}); end
         MUL_X_GAIN:  begin opa = OPA_W'(x_ff); opb = OPB_W'({1'b0, gain_ff}); end
         MUL_X_WET:   begin opa = OPA_W'(x_ff); opb = OPB_W'({1'b0, wet_ff}); end
         MUL_DRY_WET: begin opa = OPA_W'(dry_ff); opb = OPB_W'({1'b0, wetc}); end
         default: ;
      endcase
   end

   assign prod   = opa * opb;
   assign acc_in = cmd.accum ? acc_ff + ACC_W'(prod) : ACC_W'(prod);

   assign rnd_c  = (acc_ff + HALF_C) >>> COEF_BITS;
   assign rnd_16 = (acc_ff + HALF_16) >>> 16;
   assign sat_c  = (rnd_c > S32_MAX) ? S32_MAX : ((rnd_c < S32_MIN) ? S32_MIN : rnd_c);
   assign a0_t   = (rnd_c + EPS_A > ONE_A) ? ONE_A : rnd_c + EPS_A;
   assign a_t    = (ACC_W'(a0_ff) + rnd_c > ONE_A) ? ONE_A : ACC_W'(a0_ff) + rnd_c;
   assign out_sat = (x_ff > SMP_MAX) ? SMP_MAX : ((x_ff < SMP_MIN) ? SMP_MIN : x_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_sel != MUL_NONE) begin
         acc_ff <= acc_in;
      end
      if (cmd.accept) begin
         dry_ff <= SW'(req_sample_in);
         x_ff   <= SW'(req_sample_in);
      end
      if (cmd.load_state) begin
         lv_ff <= lvl_ff[idx_ff];
         tr_ff <= trd_ff[idx_ff];
      end
      case (cmd.wb_sel)
         WB_F2:  f2_ff <= CW'(rnd_c);
         WB_F3:  f3_ff <= CW'(rnd_c);
         WB_A0:  a0_ff <= CW'(a0_t);
         WB_RC:  rc_ff <= CW'(rnd_c + C012_A);
         WB_RR:  rr_ff <= CW'(rnd_c);
         WB_B:   b_ff  <= CW'(rnd_c);
         WB_A:   a_ff  <= CW'(a_t);
         WB_NT:  nt_ff <= SW'(sat_c);
         WB_Y:   y_ff  <= SW'(sat_c);
         WB_X16: begin
            x_ff    <= SW'(rnd_16);
            prev_ff <= y_ff;
         end
         WB_OUT: out_ff <= SAMPLE_BITS'(out_sat);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int i = 0; i < NUM_STAGES; i++) begin
            lvl_ff[i] <= '0;
            trd_ff[i] <= '0;
         end
      end else begin
         if (cmd.accept) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.wb_sel == WB_Y) begin
            lvl_ff[idx_ff] <= SW'(sat_c);
            trd_ff[idx_ff] <= nt_ff;
         end
      end
   end

   assign rsp_sample_out = out_ff;

endmodule
